/* rtl/core/tcce_pkg.sv */
// package: shared types, codes and command builders for the text console cursor engine
`timescale 1ns / 1ps

package tcce_pkg;

  localparam int TAB_STOP_DEF = 8;

  // configuration register indexes
  localparam logic [2:0] REG_COLUMN_COUNT    = 3'd0;
  localparam logic [2:0] REG_ROW_COUNT       = 3'd1;
  localparam logic [2:0] REG_TEXT_ATTRIBUTE  = 3'd2;
  localparam logic [2:0] REG_CLEAR_ATTRIBUTE = 3'd3;
  localparam logic [2:0] REG_CURSOR_SHOWN    = 3'd4;

  // control characters
  localparam logic [15:0] CH_BACKSPACE = 16'd8;
  localparam logic [15:0] CH_TAB       = 16'd9;
  localparam logic [15:0] CH_NEWLINE   = 16'd10;
  localparam logic [15:0] CH_RETURN    = 16'd13;
  localparam logic [15:0] CH_BLANK     = 16'd32;

  typedef enum logic [1:0] {
    CMD_PUT    = 2'd0,
    CMD_FILL   = 2'd1,
    CMD_SCROLL = 2'd2,
    CMD_CURSOR = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [7:0]  column_count;
    logic [7:0]  row_count;
    logic [15:0] text_attribute;
    logic [15:0] clear_attribute;
    logic        cursor_shown;
  } cfg_t;

  typedef struct packed {
    cmd_t        command;
    logic [7:0]  pos_x;
    logic [7:0]  pos_y;
    logic [3:0]  span_width;
    logic [15:0] glyph;
    logic [15:0] cell_attribute;
    logic        cursor_on;
  } result_t;

  // up to three commands for one character
  typedef struct packed {
    logic [1:0]        count;
    result_t [2:0]     slot;
  } bundle_t;

  function automatic result_t mk_put(logic [7:0] x, logic [7:0] y, logic [15:0] g,
                                     logic [15:0] a);
    result_t r;
    r.command        = CMD_PUT;
    r.pos_x          = x;
    r.pos_y          = y;
    r.span_width     = 4'd0;
    r.glyph          = g;
    r.cell_attribute = a;
    r.cursor_on      = 1'b0;
    return r;
  endfunction

  function automatic result_t mk_fill(logic [7:0] x, logic [7:0] y, logic [3:0] w,
                                      logic [15:0] a);
    result_t r;
    r.command        = CMD_FILL;
    r.pos_x          = x;
    r.pos_y          = y;
    r.span_width     = w;
    r.glyph          = CH_BLANK;
    r.cell_attribute = a;
    r.cursor_on      = 1'b0;
    return r;
  endfunction

  function automatic result_t mk_scroll(logic [15:0] a);
    result_t r;
    r.command        = CMD_SCROLL;
    r.pos_x          = 8'd0;
    r.pos_y          = 8'd0;
    r.span_width     = 4'd0;
    r.glyph          = CH_BLANK;
    r.cell_attribute = a;
    r.cursor_on      = 1'b0;
    return r;
  endfunction

  function automatic result_t mk_cursor(logic [7:0] x, logic [7:0] y, logic on);
    result_t r;
    r.command        = CMD_CURSOR;
    r.pos_x          = x;
    r.pos_y          = y;
    r.span_width     = 4'd0;
    r.glyph          = 16'd0;
    r.cell_attribute = 16'd0;
    r.cursor_on      = on;
    return r;
  endfunction

endpackage

/* rtl/core/tcce_cfg_regs.sv */
// configuration register bank
`timescale 1ns / 1ps

module tcce_cfg_regs (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_write_en,
  input  logic [2:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  output tcce_pkg::cfg_t    cfg
);

  tcce_pkg::cfg_t cfg_r;
  tcce_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_write_en) begin
      case (cfg_index)
        tcce_pkg::REG_COLUMN_COUNT:    cfg_nxt.column_count    = cfg_data[7:0];
        tcce_pkg::REG_ROW_COUNT:       cfg_nxt.row_count       = cfg_data[7:0];
        tcce_pkg::REG_TEXT_ATTRIBUTE:  cfg_nxt.text_attribute  = cfg_data;
        tcce_pkg::REG_CLEAR_ATTRIBUTE: cfg_nxt.clear_attribute = cfg_data;
        tcce_pkg::REG_CURSOR_SHOWN:    cfg_nxt.cursor_shown    = cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.column_count    <= 8'd80;
      cfg_r.row_count       <= 8'd25;
      cfg_r.text_attribute  <= 16'd7;
      cfg_r.clear_attribute <= 16'd7;
      cfg_r.cursor_shown    <= 1'b1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* rtl/core/tcce_decode.sv */
// character decode and cursor position registers
`timescale 1ns / 1ps

module tcce_decode #(
  parameter int TabStop = tcce_pkg::TAB_STOP_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  tcce_pkg::cfg_t    cfg,
  input  logic              accept,
  input  logic [15:0]       char_code,
  output tcce_pkg::bundle_t bundle
);

  localparam int KMax = 255 / TabStop;

  logic [7:0] col_r, col_nxt;
  logic [7:0] row_r, row_nxt;

  logic [7:0] cols;
  logic [7:0] rows;
  logic [8:0] row_inc;
  logic       nl_scroll;
  logic [7:0] nl_row;
  logic [8:0] stop;
  logic [8:0] col_inc;
  logic [8:0] span;
  logic [7:0] col_dec;

  // next tab stop: one range compare per stop, results or-ed together
  always_comb begin
    stop = 9'd0;
    for (int k = 0; k <= KMax; k++) begin
      if ((int'(col_r) >= k * TabStop) && (int'(col_r) < (k + 1) * TabStop)) begin
        stop = stop | 9'((k + 1) * TabStop);
      end
    end
  end

  always_comb begin
    cols      = (cfg.column_count == 8'd0) ? 8'd1 : cfg.column_count;
    rows      = (cfg.row_count == 8'd0) ? 8'd1 : cfg.row_count;
    row_inc   = {1'b0, row_r} + 9'd1;
    nl_scroll = row_inc >= {1'b0, rows};
    nl_row    = nl_scroll ? (rows - 8'd1) : row_inc[7:0];
    col_inc   = {1'b0, col_r} + 9'd1;
    span      = stop - {1'b0, col_r};
    col_dec   = col_r - 8'd1;
  end

  always_comb begin
    bundle  = '0;
    col_nxt = col_r;
    row_nxt = row_r;
    case (char_code)
      tcce_pkg::CH_NEWLINE: begin
        col_nxt = 8'd0;
        row_nxt = nl_row;
        if (nl_scroll) begin
          bundle.slot[0] = tcce_pkg::mk_scroll(cfg.clear_attribute);
          bundle.slot[1] = tcce_pkg::mk_cursor(8'd0, nl_row, cfg.cursor_shown);
          bundle.count   = 2'd2;
        end else begin
          bundle.slot[0] = tcce_pkg::mk_cursor(8'd0, nl_row, cfg.cursor_shown);
          bundle.count   = 2'd1;
        end
      end
      tcce_pkg::CH_RETURN: begin
        col_nxt        = 8'd0;
        bundle.slot[0] = tcce_pkg::mk_cursor(8'd0, row_r, cfg.cursor_shown);
        bundle.count   = 2'd1;
      end
      tcce_pkg::CH_TAB: begin
        if (stop >= {1'b0, cols}) begin
          // stop past the right edge: behaves as a newline
          col_nxt = 8'd0;
          row_nxt = nl_row;
          if (nl_scroll) begin
            bundle.slot[0] = tcce_pkg::mk_scroll(cfg.clear_attribute);
            bundle.slot[1] = tcce_pkg::mk_cursor(8'd0, nl_row, cfg.cursor_shown);
            bundle.count   = 2'd2;
          end else begin
            bundle.slot[0] = tcce_pkg::mk_cursor(8'd0, nl_row, cfg.cursor_shown);
            bundle.count   = 2'd1;
          end
        end else begin
          col_nxt        = stop[7:0];
          bundle.slot[0] = tcce_pkg::mk_fill(col_r, row_r, span[3:0], cfg.text_attribute);
          bundle.slot[1] = tcce_pkg::mk_cursor(stop[7:0], row_r, cfg.cursor_shown);
          bundle.count   = 2'd2;
        end
      end
      tcce_pkg::CH_BACKSPACE: begin
        if (col_r != 8'd0) begin
          col_nxt        = col_dec;
          bundle.slot[0] = tcce_pkg::mk_put(col_dec, row_r, tcce_pkg::CH_BLANK,
                                            cfg.text_attribute);
          bundle.slot[1] = tcce_pkg::mk_cursor(col_dec, row_r, cfg.cursor_shown);
          bundle.count   = 2'd2;
        end
      end
      default: begin
        bundle.slot[0] = tcce_pkg::mk_put(col_r, row_r, char_code, cfg.text_attribute);
        if (col_inc >= {1'b0, cols}) begin
          // wrap at the last column
          col_nxt = 8'd0;
          row_nxt = nl_row;
          if (nl_scroll) begin
            bundle.slot[1] = tcce_pkg::mk_scroll(cfg.clear_attribute);
            bundle.slot[2] = tcce_pkg::mk_cursor(8'd0, nl_row, cfg.cursor_shown);
            bundle.count   = 2'd3;
          end else begin
            bundle.slot[1] = tcce_pkg::mk_cursor(8'd0, nl_row, cfg.cursor_shown);
            bundle.count   = 2'd2;
          end
        end else begin
          col_nxt      = col_inc[7:0];
          bundle.count = 2'd1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= 8'd0;
      row_r <= 8'd0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

/* rtl/core/tcce_emit.sv */
// command buffer and output register, one command per transfer
`timescale 1ns / 1ps

module tcce_emit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  tcce_pkg::bundle_t bundle,
  output logic              free,
  input  logic              out_stall,
  output logic              out_valid,
  output tcce_pkg::result_t out_res,
  output logic              out_last
);

  tcce_pkg::bundle_t buf_r;
  logic              busy_r;
  logic [1:0]        idx_r;
  logic              out_valid_r;
  tcce_pkg::result_t res_r;
  logic              last_r;

  logic pop;
  logic last_slot;

  assign last_slot = idx_r == (buf_r.count - 2'd1);
  assign pop       = busy_r && (!out_valid_r || !out_stall);
  // buffer can take a new bundle when empty or its final command leaves now
  assign free      = !busy_r || (pop && last_slot);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      idx_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (load && bundle.count != 2'd0) begin
        busy_r <= 1'b1;
        idx_r  <= 2'd0;
      end else if (pop) begin
        if (last_slot) begin
          busy_r <= 1'b0;
        end else begin
          idx_r <= idx_r + 2'd1;
        end
      end
      if (pop) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      buf_r <= bundle;
    end
    if (pop) begin
      res_r  <= buf_r.slot[idx_r];
      last_r <= last_slot;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = res_r;
  assign out_last  = last_r;

endmodule

/* rtl/core/text_console_cursor_engine.sv */
// top level: text console cursor engine
//
//   port group | direction | handshake            | payload
//   in_        | input     | in_valid / in_stall  | char_code
//   out_       | output    | out_valid / out_stall| command, pos, span, glyph, attribute,
//              |           |                      | cursor_on, last
//   cfg_       | input     | cfg_write_en         | cfg_index, cfg_data
//
// a character is decoded in the cycle of its transfer and its one to three commands
// are loaded into a buffer; the buffer sends one command per cycle into the output
// register while out_stall does not hold it, and the next character transfers in the
// cycle its predecessor's final command leaves.
// backspace at column 0 has no command and does not occupy the buffer.
// synchronous active-low reset puts the cursor at 0,0 and the registers to defaults.
// out_stall holds the output register and, once the buffer is full, stalls the input.
`timescale 1ns / 1ps

module text_console_cursor_engine #(
  parameter int TabStop = tcce_pkg::TAB_STOP_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_write_en,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_char_code,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_command,
  output logic [7:0]  out_pos_x,
  output logic [7:0]  out_pos_y,
  output logic [3:0]  out_span_width,
  output logic [15:0] out_glyph,
  output logic [15:0] out_cell_attribute,
  output logic        out_cursor_on,
  output logic        out_last
);

  tcce_pkg::cfg_t    cfg;
  tcce_pkg::bundle_t bundle;
  tcce_pkg::result_t res;
  logic              free;
  logic              accept;

  assign in_stall = !free;
  assign accept   = in_valid && free;

  tcce_cfg_regs u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cfg          (cfg)
  );

  tcce_decode #(
    .TabStop (TabStop)
  ) u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .accept    (accept),
    .char_code (in_char_code),
    .bundle    (bundle)
  );

  tcce_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (accept),
    .bundle    (bundle),
    .free      (free),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_res   (res),
    .out_last  (out_last)
  );

  assign out_command        = res.command;
  assign out_pos_x          = res.pos_x;
  assign out_pos_y          = res.pos_y;
  assign out_span_width     = res.span_width;
  assign out_glyph          = res.glyph;
  assign out_cell_attribute = res.cell_attribute;
  assign out_cursor_on      = res.cursor_on;

endmodule

/* sim/text_console_cursor_engine_tb.sv */
// testbench: text console cursor engine, directed table then random characters
`timescale 1ns / 1ps

module text_console_cursor_engine_tb;

  localparam int TAB_W = tcce_pkg::TAB_STOP_DEF;
  localparam int SETTLE_CYCLES = 6;
  localparam int PHASES = 8;
  localparam int CHARS_PER_PHASE = 35;

  typedef struct packed {
    tcce_pkg::cmd_t command;
    logic [7:0]     pos_x;
    logic [7:0]     pos_y;
    logic [3:0]     span_width;
    logic [15:0]    glyph;
    logic [15:0]    cell_attribute;
    logic           cursor_on;
    logic           last;
  } display_cmd_t;

  typedef struct {
    bit           is_cfg;
    logic [2:0]   reg_idx;
    logic [15:0]  value;
    int           typed_n;
    display_cmd_t typed_cmd;
  } plan_row_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_write_en;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [15:0] in_char_code;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_command;
  logic [7:0]  out_pos_x;
  logic [7:0]  out_pos_y;
  logic [3:0]  out_span_width;
  logic [15:0] out_glyph;
  logic [15:0] out_cell_attribute;
  logic        out_cursor_on;
  logic        out_last;

  text_console_cursor_engine #(.TabStop(TAB_W)) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_write_en       (cfg_write_en),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_char_code       (in_char_code),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_command        (out_command),
    .out_pos_x          (out_pos_x),
    .out_pos_y          (out_pos_y),
    .out_span_width     (out_span_width),
    .out_glyph          (out_glyph),
    .out_cell_attribute (out_cell_attribute),
    .out_cursor_on      (out_cursor_on),
    .out_last           (out_last)
  );

  // shadow of the screen settings and cursor
  logic [7:0]  scr_cols;
  logic [7:0]  scr_rows;
  logic [15:0] attr_text;
  logic [15:0] attr_clear;
  logic        show_cursor;
  logic [7:0]  cur_col;
  logic [7:0]  cur_row;

  display_cmd_t char_batch[$];
  display_cmd_t expected_cmds[$];
  plan_row_t    plan[$];

  int mismatch_count = 0;
  int idle_pct = 30;
  int stall_pct = 30;
  int stall_left = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("text_console_cursor_engine test failed");
    $finish;
  end

  function automatic display_cmd_t mk_cmd(tcce_pkg::cmd_t c, logic [7:0] x, logic [7:0] y,
                                          logic [3:0] w, logic [15:0] g, logic [15:0] a,
                                          logic on, logic fin);
    display_cmd_t d;
    d.command        = c;
    d.pos_x          = x;
    d.pos_y          = y;
    d.span_width     = w;
    d.glyph          = g;
    d.cell_attribute = a;
    d.cursor_on      = on;
    d.last           = fin;
    return d;
  endfunction

  function automatic void queue_cmd(tcce_pkg::cmd_t c, logic [7:0] x, logic [7:0] y,
                                    logic [3:0] w, logic [15:0] g, logic [15:0] a,
                                    logic on);
    char_batch.push_back(mk_cmd(c, x, y, w, g, a, on, 1'b0));
  endfunction

  function automatic void queue_cursor();
    queue_cmd(tcce_pkg::CMD_CURSOR, cur_col, cur_row, 4'd0, 16'd0, 16'd0, show_cursor);
  endfunction

  function automatic void model_newline();
    int rows_e;
    int nxt;
    rows_e = (scr_rows == 8'd0) ? 1 : int'(scr_rows);
    nxt = int'(cur_row) + 1;
    cur_col = 8'd0;
    // a row at or past the bottom scrolls and pins the cursor to the last row
    if (nxt >= rows_e) begin
      queue_cmd(tcce_pkg::CMD_SCROLL, 8'd0, 8'd0, 4'd0, tcce_pkg::CH_BLANK, attr_clear,
                1'b0);
      nxt = rows_e - 1;
    end
    cur_row = nxt[7:0];
    queue_cursor();
  endfunction

  function automatic void predict_char(logic [15:0] ch);
    int cols_e;
    int stop;
    int w;
    char_batch.delete();
    cols_e = (scr_cols == 8'd0) ? 1 : int'(scr_cols);
    case (ch)
      tcce_pkg::CH_NEWLINE: model_newline();
      tcce_pkg::CH_RETURN: begin
        cur_col = 8'd0;
        queue_cursor();
      end
      tcce_pkg::CH_TAB: begin
        stop = (int'(cur_col) / TAB_W + 1) * TAB_W;
        if (stop >= cols_e) begin
          model_newline();
        end else begin
          w = stop - int'(cur_col);
          queue_cmd(tcce_pkg::CMD_FILL, cur_col, cur_row, w[3:0], tcce_pkg::CH_BLANK,
                    attr_text, 1'b0);
          cur_col = stop[7:0];
          queue_cursor();
        end
      end
      tcce_pkg::CH_BACKSPACE: begin
        if (cur_col != 8'd0) begin
          cur_col = cur_col - 8'd1;
          queue_cmd(tcce_pkg::CMD_PUT, cur_col, cur_row, 4'd0, tcce_pkg::CH_BLANK,
                    attr_text, 1'b0);
          queue_cursor();
        end
      end
      default: begin
        queue_cmd(tcce_pkg::CMD_PUT, cur_col, cur_row, 4'd0, ch, attr_text, 1'b0);
        if (int'(cur_col) + 1 >= cols_e) model_newline();
        else cur_col = cur_col + 8'd1;
      end
    endcase
    if (char_batch.size() > 0) char_batch[char_batch.size() - 1].last = 1'b1;
  endfunction

  function automatic void apply_cfg(logic [2:0] idx, logic [15:0] v);
    case (idx)
      tcce_pkg::REG_COLUMN_COUNT:    scr_cols = v[7:0];
      tcce_pkg::REG_ROW_COUNT:       scr_rows = v[7:0];
      tcce_pkg::REG_TEXT_ATTRIBUTE:  attr_text = v;
      tcce_pkg::REG_CLEAR_ATTRIBUTE: attr_clear = v;
      tcce_pkg::REG_CURSOR_SHOWN:    show_cursor = v[0];
      default: ;
    endcase
  endfunction

  function automatic void add_typed(logic [15:0] ch, int n, display_cmd_t c);
    plan_row_t r;
    r.is_cfg    = 1'b0;
    r.reg_idx   = tcce_pkg::REG_COLUMN_COUNT;
    r.value     = ch;
    r.typed_n   = n;
    r.typed_cmd = c;
    plan.push_back(r);
  endfunction

  function automatic void add_char(logic [15:0] ch);
    add_typed(ch, -1, '0);
  endfunction

  function automatic void add_cfg(logic [2:0] idx, logic [15:0] v);
    plan_row_t r;
    r.is_cfg    = 1'b1;
    r.reg_idx   = idx;
    r.value     = v;
    r.typed_n   = -1;
    r.typed_cmd = '0;
    plan.push_back(r);
  endfunction

  function automatic logic [7:0] pick_size();
    case ($urandom_range(0, 5))
      0: return 8'd0;
      1: return 8'd1;
      2: return 8'd255;
      default: return 8'($urandom_range(2, 24));
    endcase
  endfunction

  function automatic logic [15:0] with_noise(logic [7:0] lo);
    logic [15:0] r;
    r = 16'($urandom);
    r[7:0] = lo;
    return r;
  endfunction

  function automatic logic [15:0] rand_char();
    case ($urandom_range(0, 9))
      0: return tcce_pkg::CH_NEWLINE;
      1: return tcce_pkg::CH_RETURN;
      2, 3: return tcce_pkg::CH_TAB;
      4: return tcce_pkg::CH_BACKSPACE;
      5, 6: return 16'($urandom_range(32, 126));
      7: return 16'($urandom_range(0, 31));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("mismatch: %s got %0h expected %0h", what, got, want);
    mismatch_count++;
  endtask

  task automatic compare_field(string what, logic [15:0] got, logic [15:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  task automatic send_char(logic [15:0] ch, int typed_n, display_cmd_t typed_cmd);
    @(negedge clk);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_char_code = ch;
    do @(posedge clk); while (in_stall);
    predict_char(ch);
    // rows with a hand-written expectation replace the predicted commands
    if (typed_n >= 0) begin
      char_batch.delete();
      if (typed_n > 0) char_batch.push_back(typed_cmd);
    end
    foreach (char_batch[k]) expected_cmds.push_back(char_batch[k]);
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    wait (expected_cmds.size() == 0);
    // a backspace at column 0 may still be in flight with nothing expected
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] v);
    @(negedge clk);
    cfg_write_en = 1'b1;
    cfg_index = idx;
    cfg_data = v;
    apply_cfg(idx, v);
    @(negedge clk);
    cfg_write_en = 1'b0;
  endtask

  // receiver back-pressure in bursts of random length
  always @(negedge clk) begin
    if (stall_left != 0) begin
      out_stall = 1'b1;
      stall_left--;
    end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
      out_stall = 1'b1;
      stall_left = $urandom_range(0, 3);
    end else begin
      out_stall = 1'b0;
    end
  end

  always @(posedge clk) begin
    display_cmd_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_cmds.size() == 0) begin
        report_mismatch("command with none pending", {14'd0, out_command}, 16'd0);
      end else begin
        want = expected_cmds.pop_front();
        compare_field("command", {14'd0, out_command}, {14'd0, want.command});
        compare_field("pos_x", {8'd0, out_pos_x}, {8'd0, want.pos_x});
        compare_field("pos_y", {8'd0, out_pos_y}, {8'd0, want.pos_y});
        compare_field("span_width", {12'd0, out_span_width}, {12'd0, want.span_width});
        compare_field("glyph", out_glyph, want.glyph);
        compare_field("cell_attribute", out_cell_attribute, want.cell_attribute);
        compare_field("cursor_on", {15'd0, out_cursor_on}, {15'd0, want.cursor_on});
        compare_field("last", {15'd0, out_last}, {15'd0, want.last});
      end
    end
  end

  initial begin
    bit          in_cfg;
    logic [7:0]  size;
    logic [2:0]  spare_idx;
    rst_n = 1'b0;
    cfg_write_en = 1'b0;
    cfg_index = tcce_pkg::REG_COLUMN_COUNT;
    cfg_data = 16'd0;
    in_valid = 1'b0;
    in_char_code = 16'd0;
    scr_cols = 8'd80;
    scr_rows = 8'd25;
    attr_text = 16'd7;
    attr_clear = 16'd7;
    show_cursor = 1'b1;
    cur_col = 8'd0;
    cur_row = 8'd0;

    // defaults after reset, hand-checked where obvious
    add_typed(16'd65, 1, mk_cmd(tcce_pkg::CMD_PUT, 8'd0, 8'd0, 4'd0, 16'd65, 16'd7,
                                1'b0, 1'b1));
    add_char(tcce_pkg::CH_BACKSPACE);
    add_typed(tcce_pkg::CH_BACKSPACE, 0, '0);
    add_typed(16'hffff, 1, mk_cmd(tcce_pkg::CMD_PUT, 8'd0, 8'd0, 4'd0, 16'hffff, 16'd7,
                                  1'b0, 1'b1));
    add_typed(16'h0000, 1, mk_cmd(tcce_pkg::CMD_PUT, 8'd1, 8'd0, 4'd0, 16'h0000, 16'd7,
                                  1'b0, 1'b1));
    add_char(tcce_pkg::CH_TAB);
    add_char(tcce_pkg::CH_RETURN);
    add_char(tcce_pkg::CH_NEWLINE);
    // small screen: tab past the edge, scroll at the bottom, wrap at the last column
    add_cfg(tcce_pkg::REG_COLUMN_COUNT, 16'd10);
    add_cfg(tcce_pkg::REG_ROW_COUNT, 16'd3);
    add_cfg(tcce_pkg::REG_TEXT_ATTRIBUTE, 16'hffff);
    add_cfg(tcce_pkg::REG_CLEAR_ATTRIBUTE, 16'h0000);
    add_cfg(tcce_pkg::REG_CURSOR_SHOWN, 16'd0);
    add_char(tcce_pkg::CH_TAB);
    add_char(tcce_pkg::CH_TAB);
    add_char(tcce_pkg::CH_NEWLINE);
    add_char(tcce_pkg::CH_TAB);
    add_char(16'd113);
    add_char(16'd114);
    add_char(tcce_pkg::CH_TAB);
    // shrink the screen under the cursor
    add_cfg(tcce_pkg::REG_COLUMN_COUNT, 16'd4);
    add_cfg(tcce_pkg::REG_ROW_COUNT, 16'd2);
    add_char(16'd109);
    add_char(tcce_pkg::CH_TAB);
    // zero sizes behave as one
    add_cfg(tcce_pkg::REG_COLUMN_COUNT, 16'd0);
    add_cfg(tcce_pkg::REG_ROW_COUNT, 16'd0);
    add_cfg(tcce_pkg::REG_CLEAR_ATTRIBUTE, 16'hffff);
    add_cfg(tcce_pkg::REG_CURSOR_SHOWN, 16'd1);
    add_char(16'd122);
    add_char(tcce_pkg::CH_TAB);
    add_char(tcce_pkg::CH_BACKSPACE);
    add_char(tcce_pkg::CH_RETURN);
    // largest screen
    add_cfg(tcce_pkg::REG_COLUMN_COUNT, 16'd255);
    add_cfg(tcce_pkg::REG_ROW_COUNT, 16'd255);
    add_cfg(tcce_pkg::REG_TEXT_ATTRIBUTE, 16'h0000);
    add_char(tcce_pkg::CH_TAB);
    add_char(tcce_pkg::CH_BACKSPACE);
    add_char(tcce_pkg::CH_NEWLINE);
    add_char(16'd107);
    add_char(16'd126);

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    in_cfg = 1'b0;
    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        if (!in_cfg) settle();
        write_reg(plan[i].reg_idx, plan[i].value);
        in_cfg = 1'b1;
      end else begin
        send_char(plan[i].value, plan[i].typed_n, plan[i].typed_cmd);
        in_cfg = 1'b0;
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      size = (ph == 1) ? 8'd255 : (ph == 2) ? 8'd0 : pick_size();
      write_reg(tcce_pkg::REG_COLUMN_COUNT, with_noise(size));
      size = (ph == 1) ? 8'd255 : (ph == 2) ? 8'd0 : pick_size();
      write_reg(tcce_pkg::REG_ROW_COUNT, with_noise(size));
      write_reg(tcce_pkg::REG_TEXT_ATTRIBUTE, (ph == 1) ? 16'hffff : 16'($urandom));
      write_reg(tcce_pkg::REG_CLEAR_ATTRIBUTE, (ph == 2) ? 16'h0000 : 16'($urandom));
      write_reg(tcce_pkg::REG_CURSOR_SHOWN, 16'($urandom));
      // writes to unused indexes must leave everything alone
      spare_idx = tcce_pkg::REG_CURSOR_SHOWN + 3'($urandom_range(1, 3));
      write_reg(spare_idx, 16'($urandom));
      if (ph == PHASES - 1) begin
        idle_pct = 0;
        stall_pct = 0;
      end else begin
        idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 50);
        stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 50);
      end
      repeat (CHARS_PER_PHASE) send_char(rand_char(), -1, '0);
    end

    settle();
    if (mismatch_count == 0) begin
      $display("text_console_cursor_engine test passed");
    end else begin
      $display("text_console_cursor_engine test failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/tcce_pkg.sv
rtl/core/tcce_cfg_regs.sv
rtl/core/tcce_decode.sv
rtl/core/tcce_emit.sv
rtl/core/text_console_cursor_engine.sv
sim/text_console_cursor_engine_tb.sv
